>>> src/mwsr_pkg.sv
`default_nettype none

package mwsr_pkg;

    // Fixed-point layout of the cell words
    localparam int FRAC       = 16;
    localparam int WORD_W     = 32;
    localparam int GAMMA_W    = 14;
    localparam int ONE_Q12    = 4096;
    localparam int DIV_W      = 52;   // widest dividend: (g << FRAC)
    localparam int DIVISOR_W  = 31;   // positive density
    localparam int ROOT_W     = 32;
    localparam int RAD_W      = 2 * ROOT_W;

    // One cell word as held between front and back
    typedef struct packed {
        logic [WORD_W-1:0] density;
        logic [WORD_W-1:0] momentum_x;
        logic [WORD_W-1:0] momentum_y;
        logic [WORD_W-1:0] momentum_z;
        logic [WORD_W-1:0] total_energy;
        logic              last_cell;
        logic              skip;
    } t_cell;

    typedef enum logic [4:0] {
        S_IDLE,
        S_UGO,
        S_UWAIT,
        S_USQ,
        S_UACC,
        S_KIN,
        S_DIFF,
        S_PRES,
        S_GAM,
        S_AGO,
        S_AWAIT,
        S_SQA_GO,
        S_SQA_WAIT,
        S_SQS_GO,
        S_SQS_WAIT,
        S_WAVE,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> src/mwsr_front.sv
`default_nettype none

module mwsr_front
    import mwsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cell i_cell,
    output logic       o_full,
    output logic       o_valid,
    output t_cell      o_cell,
    input  wire logic  i_take
);

    t_cell       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        wr;
    logic        rd;
    t_cell       cls;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cell  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_valid;

    // Classify: mark cells with non-positive density for skipping
    always_comb begin
        cls      = i_cell;
        cls.skip = i_cell.density[WORD_W-1] || (i_cell.density == '0);
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cls;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/mwsr_div.sv
`default_nettype none

module mwsr_div
    import mwsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_W-1:0]     i_dividend,
    input  wire logic [DIVISOR_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [DIV_W-1:0]          o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_dvs;
    logic [DIV_W-1:0]     r_quo;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign trial  = {r_rem, r_quo[DIV_W-1]};
    assign fits   = (trial >= {1'b0, r_dvs});
    assign o_done = r_done;
    assign o_quot = r_quo;

    // Restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? DIVISOR_W'(trial - {1'b0, r_dvs}) : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

>>> src/mwsr_sqrt.sv
`default_nettype none

module mwsr_sqrt
    import mwsr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAD_W-1:0]  i_radicand,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              fits;

    assign cur    = {r_rem, r_x[RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign fits   = (cur >= trial);
    assign o_done = r_done;
    assign o_root = r_root;

    // Digit-by-digit square root, two radicand bits a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_W-3:0], 2'b00};
            r_rem  <= fits ? REM_W'(cur - trial) : REM_W'(cur);
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

>>> src/mwsr_back.sv
`default_nettype none

module mwsr_back
    import mwsr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_cell              i_cell,
    output logic                    o_take,
    input  wire logic [GAMMA_W-1:0] i_gamma,
    input  wire logic               i_room,
    output logic                    o_emit,
    output logic [WORD_W-1:0]       o_emit_value
);

    localparam logic [WORD_W-1:0] SMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [47:0]       A2_CAP = {48{1'b1}};

    t_state              r_state;
    t_state              n_state;
    t_cell               r_cell;
    logic [1:0]          r_axis;
    logic [WORD_W-1:0]   r_mag;
    logic [63:0]         r_sq;
    logic [63:0]         r_s2;
    logic [45:0]         r_kin;
    logic signed [46:0]  r_d;
    logic signed [46:0]  r_pr;
    logic [35:0]         r_g;
    logic [47:0]         r_a2;
    logic [ROOT_W-1:0]   r_a;
    logic [ROOT_W-1:0]   r_speed;
    logic [WORD_W-1:0]   r_max;

    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_quot;
    logic                sq_start;
    logic                sq_done;
    logic [RAD_W-1:0]    sq_rad;
    logic [ROOT_W-1:0]   sq_root;

    logic [WORD_W-1:0]   mom;
    logic [WORD_W-1:0]   mom_abs;
    logic [WORD_W-1:0]   lim;
    logic [WORD_W-1:0]   q_sat;
    logic [62:0]         kin_full;
    logic signed [47:0]  diff;
    logic signed [WORD_W-1:0] d_sat;
    logic signed [46:0]  gm1;
    logic [47:0]         g_full;
    logic [ROOT_W:0]     wave;
    logic [WORD_W-1:0]   wave_sat;

    // Select momentum for the current axis
    always_comb begin
        case (r_axis)
            2'd0:    mom = r_cell.momentum_x;
            2'd1:    mom = r_cell.momentum_y;
            default: mom = r_cell.momentum_z;
        endcase
        mom_abs = mom[WORD_W-1] ? (~mom + WORD_W'(1)) : mom;
        lim     = mom[WORD_W-1] ? SMIN : SMAX;
    end

    // Kinetic term, pressure and wave speed arithmetic
    always_comb begin
        q_sat    = (|r_s2[63:FRAC+WORD_W]) ? '1 : r_s2[FRAC+WORD_W-1:FRAC];
        kin_full = 63'(r_cell.density[DIVISOR_W-1:0]) * 63'(q_sat);
        diff     = 48'(signed'(r_cell.total_energy)) - signed'({2'b00, r_kin});
        if (diff > 48'(signed'(SMAX)))      d_sat = signed'(SMAX);
        else if (diff < 48'(signed'(SMIN))) d_sat = signed'(SMIN);
        else                                d_sat = diff[WORD_W-1:0];
        gm1      = 47'(signed'({1'b0, i_gamma})) - 47'(ONE_Q12);
        g_full   = 48'(i_gamma) * 48'(r_pr[45:12]);
        wave     = {1'b0, r_speed} + {1'b0, r_a};
        wave_sat = wave[ROOT_W] ? '1 : wave[ROOT_W-1:0];
    end

    assign div_dividend = (r_state == S_AGO)
                        ? DIV_W'({r_g, {FRAC{1'b0}}})
                        : DIV_W'({mom_abs, {FRAC{1'b0}}});
    assign sq_rad       = (r_state == S_SQA_GO) ? {r_a2, {FRAC{1'b0}}} : r_s2;

    mwsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_cell.density[DIVISOR_W-1:0]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    mwsr_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_valid) n_state = i_cell.skip ? S_FINISH : S_UGO;
            S_UGO:      n_state = S_UWAIT;
            S_UWAIT:    if (div_done) n_state = S_USQ;
            S_USQ:      n_state = S_UACC;
            S_UACC:     n_state = (r_axis == 2'd2) ? S_KIN : S_UGO;
            S_KIN:      n_state = S_DIFF;
            S_DIFF:     n_state = S_PRES;
            S_PRES:     n_state = S_GAM;
            S_GAM:      n_state = r_pr[46] ? S_FINISH : S_AGO;
            S_AGO:      n_state = S_AWAIT;
            S_AWAIT:    if (div_done) n_state = S_SQA_GO;
            S_SQA_GO:   n_state = S_SQA_WAIT;
            S_SQA_WAIT: if (sq_done) n_state = S_SQS_GO;
            S_SQS_GO:   n_state = S_SQS_WAIT;
            S_SQS_WAIT: if (sq_done) n_state = S_WAVE;
            S_WAVE:     n_state = S_FINISH;
            S_FINISH:   if (!r_cell.last_cell || i_room) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_take    = 1'b0;
        div_start = 1'b0;
        sq_start  = 1'b0;
        o_emit    = 1'b0;
        unique case (r_state)
            S_IDLE:   o_take    = i_valid;
            S_UGO:    div_start = 1'b1;
            S_AGO:    div_start = 1'b1;
            S_SQA_GO: sq_start  = 1'b1;
            S_SQS_GO: sq_start  = 1'b1;
            S_FINISH: o_emit    = r_cell.last_cell && i_room;
            default:  o_emit    = 1'b0;
        endcase
    end

    assign o_emit_value = r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the running maximum; clear it once emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (o_emit) begin
            r_max <= '0;
        end else if (r_state == S_WAVE && wave_sat > r_max) begin
            r_max <= wave_sat;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cell <= i_cell;
                r_axis <= 2'd0;
                r_s2   <= '0;
            end
            S_UWAIT: begin
                if (div_done) begin
                    r_mag <= (div_quot > DIV_W'(lim)) ? lim : div_quot[WORD_W-1:0];
                end
            end
            S_USQ:    r_sq  <= 64'(r_mag) * 64'(r_mag);
            S_UACC: begin
                r_s2   <= r_s2 + r_sq;
                r_axis <= r_axis + 2'd1;
            end
            S_KIN:    r_kin <= kin_full[62:FRAC+1];
            S_DIFF:   r_d   <= 47'(d_sat);
            S_PRES:   r_pr  <= gm1 * r_d;
            S_GAM:    r_g   <= g_full[47:12];
            S_AWAIT: begin
                if (div_done) begin
                    r_a2 <= (|div_quot[DIV_W-1:48]) ? A2_CAP : div_quot[47:0];
                end
            end
            S_SQA_WAIT: if (sq_done) r_a <= sq_root;
            S_SQS_WAIT: if (sq_done) r_speed <= sq_root;
            default:  r_axis <= r_axis;
        endcase
    end

endmodule

`default_nettype wire

>>> src/max_wave_speed_reduction.sv
// Channel   | Handshake           | Word
// ----------+---------------------+--------------------------------------------
// cell in   | push / full         | i_density, i_momentum_x/y/z, i_total_energy,
//           |                     | i_last_cell
// result    | empty / pop         | o_max_speed
// config    | i_gamma_we          | i_gamma_q12
//
// In the back end a cell runs three serial divisions for the velocity, one division
// for the sound speed squared and two square roots, plus a few multiply steps.
// Skipped cells bypass the arithmetic and go straight to the finish state.
// A two-word cell queue feeds the back end; one output register holds the result.
// Reset is synchronous, active low; it clears the maximum and sets gamma to 1.4.
`default_nettype none

module max_wave_speed_reduction
    import mwsr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [WORD_W-1:0]  i_density,
    input  wire logic [WORD_W-1:0]  i_momentum_x,
    input  wire logic [WORD_W-1:0]  i_momentum_y,
    input  wire logic [WORD_W-1:0]  i_momentum_z,
    input  wire logic [WORD_W-1:0]  i_total_energy,
    input  wire logic               i_last_cell,
    output logic                    empty,
    input  wire logic               pop,
    output logic [WORD_W-1:0]       o_max_speed,
    input  wire logic               i_gamma_we,
    input  wire logic [GAMMA_W-1:0] i_gamma_q12
);

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(5734);

    logic [GAMMA_W-1:0] r_gamma;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out;
    t_cell              in_cell;
    t_cell              q_cell;
    logic               q_valid;
    logic               q_take;
    logic               room;
    logic               emit;
    logic [WORD_W-1:0]  emit_value;

    always_comb begin
        in_cell.density      = i_density;
        in_cell.momentum_x   = i_momentum_x;
        in_cell.momentum_y   = i_momentum_y;
        in_cell.momentum_z   = i_momentum_z;
        in_cell.total_energy = i_total_energy;
        in_cell.last_cell    = i_last_cell;
        in_cell.skip         = 1'b0;
    end

    mwsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (in_cell),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cell  (q_cell),
        .i_take  (q_take)
    );

    mwsr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_cell       (q_cell),
        .o_take       (q_take),
        .i_gamma      (r_gamma),
        .i_room       (room),
        .o_emit       (emit),
        .o_emit_value (emit_value)
    );

    // Hold gamma
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (i_gamma_we) begin
            r_gamma <= i_gamma_q12;
        end
    end

    // Output register: refill as the old word leaves
    assign room        = !r_out_valid || pop;
    assign empty       = !r_out_valid;
    assign o_max_speed = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_value;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || pop))
        else $error("result emitted over a waiting word");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> !empty)
        else $error("emitted result not presented");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_take |-> q_valid)
        else $error("cell taken from an empty queue");

endmodule

`default_nettype wire
